/* hw/rtl/assert_macros.svh */
// Assertion shorthands shared by the RTL; clk and rst_n are taken from the
// scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds whenever the antecedent does
`define AST_IMPLY(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("implication check failed");

// Check that a condition never occurs outside reset
`define AST_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hw/rtl/pcc_pkg.sv */
package pcc_pkg;

  // Binary angle width fed to the sine unit and position fraction width
  localparam int ANGLE_BITS    = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int QS            = ANGLE_BITS - 2;
  localparam int COV_SHIFT     = 2 * POS_FRAC_BITS;

  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [32:0] TWO32       = 33'h1_0000_0000;

  // Horner divisors and their truncated 2^32 reciprocals
  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [COS_STEPS] =
    '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
    32'(TWO32 / 156), 32'(TWO32 / 110), 32'(TWO32 / 72),
    32'(TWO32 / 42), 32'(TWO32 / 20), 32'(TWO32 / 6)};
  localparam logic [31:0] COS_RCP [COS_STEPS] = '{
    32'(TWO32 / 182), 32'(TWO32 / 132), 32'(TWO32 / 90), 32'(TWO32 / 56),
    32'(TWO32 / 30), 32'(TWO32 / 12), 32'(TWO32 / 2)};

  // Pipeline depths
  localparam int LINE_LEN = 3 * COS_STEPS;
  localparam int SC_LAT   = LINE_LEN + 4;
  localparam int BK_LAT   = 8;
  localparam int LAT      = SC_LAT + BK_LAT;

  // Sine unit result
  typedef struct packed {
    logic               vld;
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sc_res_t;

  // Values carried down the Horner chains
  typedef struct packed {
    logic [1:0]  q;
    logic [30:0] t;
    logic [31:0] u;
  } sc_car_t;

endpackage

/* hw/rtl/pcc_sincos.sv */
module pcc_sincos import pcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [ANGLE_BITS-1:0] in_angle,
  output sc_res_t               res
);

  logic [SC_LAT:1]   vld_r;
  logic [1:0]        q1_r, q2_r, q3_r;
  logic [QS+30:0]    pt_r;
  logic [30:0]       t2_r, t3_r;
  logic [61:0]       tt_r;
  sc_car_t           line0;
  sc_car_t           line_r [1:LINE_LEN];
  logic [62:0]       sm_r [SIN_STEPS];
  logic [31:0]       sv_r [SIN_STEPS];
  logic [63:0]       sn_r [SIN_STEPS];
  logic [30:0]       sp_r [SIN_STEPS];
  logic [62:0]       cm_r [COS_STEPS];
  logic [31:0]       cv_r [COS_STEPS];
  logic [63:0]       cn_r [COS_STEPS];
  logic [30:0]       cp_r [COS_STEPS];
  logic [61:0]       fm_r;
  logic [30:0]       fs_r, fsd_r;
  logic signed [31:0] s_r, c_r;
  logic signed [31:0] s_nxt, c_nxt;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SC_LAT-1:1], in_vld};
    end
  end

  // Map the angle to theta in unsigned Q1.30 and square it
  always_ff @(posedge clk) begin
    q1_r <= in_angle[ANGLE_BITS-1 -: 2];
    pt_r <= (QS+31)'(in_angle[QS-1:0]) * (QS+31)'(HALF_PI_Q30);
    q2_r <= q1_r;
    t2_r <= 31'(pt_r >> QS);
    q3_r <= q2_r;
    t3_r <= t2_r;
    tt_r <= 62'(t2_r) * 62'(t2_r);
  end

  assign line0 = '{q: q3_r, t: t3_r, u: tt_r[61:30]};

  // Carry quadrant, theta and theta squared beside the chains
  always_ff @(posedge clk) begin
    line_r[1] <= line0;
    for (int j = 2; j <= LINE_LEN; j++) begin
      line_r[j] <= line_r[j-1];
    end
  end

  // Sine chain: one Horner step every three stages
  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    logic [31:0] u_in;
    logic [30:0] p_in;
    logic [31:0] q0;
    logic [39:0] rem;
    logic [32:0] term;
    logic [30:0] p_nxt;
    if (i == 0) begin : g_first
      assign u_in = line0.u;
      assign p_in = ONE_Q30;
    end else begin : g_next
      assign u_in = line_r[3*i].u;
      assign p_in = sp_r[i-1];
    end
    // Correct the reciprocal quotient by at most one
    always_comb begin
      q0    = sn_r[i][63:32];
      rem   = 40'(sv_r[i]) - 40'(q0) * 40'(SIN_DIV[i]);
      term  = (rem >= 40'(SIN_DIV[i])) ? 33'(q0) + 33'd1 : 33'(q0);
      p_nxt = (term > 33'(ONE_Q30)) ? '0 : 31'(33'(ONE_Q30) - term);
    end
    always_ff @(posedge clk) begin
      sm_r[i] <= 63'(u_in) * 63'(p_in);
      sv_r[i] <= sm_r[i][61:30];
      sn_r[i] <= 64'(sm_r[i][61:30]) * 64'(SIN_RCP[i]);
      sp_r[i] <= p_nxt;
    end
  end

  // Cosine chain
  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    logic [31:0] u_in;
    logic [30:0] p_in;
    logic [31:0] q0;
    logic [39:0] rem;
    logic [32:0] term;
    logic [30:0] p_nxt;
    if (i == 0) begin : g_first
      assign u_in = line0.u;
      assign p_in = ONE_Q30;
    end else begin : g_next
      assign u_in = line_r[3*i].u;
      assign p_in = cp_r[i-1];
    end
    always_comb begin
      q0    = cn_r[i][63:32];
      rem   = 40'(cv_r[i]) - 40'(q0) * 40'(COS_DIV[i]);
      term  = (rem >= 40'(COS_DIV[i])) ? 33'(q0) + 33'd1 : 33'(q0);
      p_nxt = (term > 33'(ONE_Q30)) ? '0 : 31'(33'(ONE_Q30) - term);
    end
    always_ff @(posedge clk) begin
      cm_r[i] <= 63'(u_in) * 63'(p_in);
      cv_r[i] <= cm_r[i][61:30];
      cn_r[i] <= 64'(cm_r[i][61:30]) * 64'(COS_RCP[i]);
      cp_r[i] <= p_nxt;
    end
  end

  // Finish the sine, clamp it and hold it level with the cosine
  always_ff @(posedge clk) begin
    fm_r  <= 62'(line_r[3*SIN_STEPS].t) * 62'(sp_r[SIN_STEPS-1]);
    fs_r  <= (fm_r[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : fm_r[60:30];
    fsd_r <= fs_r;
  end

  // Unfold the quadrant
  always_comb begin
    case (line_r[LINE_LEN].q)
      2'd0: begin
        s_nxt = $signed({1'b0, fsd_r});
        c_nxt = $signed({1'b0, cp_r[COS_STEPS-1]});
      end
      2'd1: begin
        s_nxt = $signed({1'b0, cp_r[COS_STEPS-1]});
        c_nxt = -$signed({1'b0, fsd_r});
      end
      2'd2: begin
        s_nxt = -$signed({1'b0, fsd_r});
        c_nxt = -$signed({1'b0, cp_r[COS_STEPS-1]});
      end
      default: begin
        s_nxt = -$signed({1'b0, cp_r[COS_STEPS-1]});
        c_nxt = $signed({1'b0, fsd_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    c_r <= c_nxt;
  end

  assign res = '{vld: vld_r[SC_LAT], s: s_r, c: c_r};

endmodule

/* hw/rtl/pose_compose_with_covariance_unit.sv */
// Composes a base pose with a relative pose and spreads the heading variance
// into the position covariance.
// Input: drive the in_ fields and raise start; the transfer happens at the
// rising edge where start is high and busy is low. busy is only high while
// rst_n is low, so one item can enter on every cycle.
// Output: out_valid marks one cycle holding a result; the transfer happens at
// the edge that ends it and the receiver cannot hold it off.
// The sine/cosine unit (two Horner chains of up to seven steps, three stages per step)
// feeds the back end, whose registers form the rotation and covariance products.
// Throughput: one item per cycle, results in input order.
// Reset: synchronous rst_n clears every valid bit; items in flight are dropped.
`include "assert_macros.svh"
module pose_compose_with_covariance_unit import pcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_base_x,
  input  logic signed [31:0] in_base_y,
  input  logic [15:0]        in_base_heading,
  input  logic [31:0]        in_var_xx,
  input  logic signed [31:0] in_cov_xy,
  input  logic [31:0]        in_var_yy,
  input  logic [31:0]        in_var_heading,
  input  logic signed [31:0] in_rel_x,
  input  logic signed [31:0] in_rel_y,
  input  logic [15:0]        in_rel_heading,
  input  logic [47:0]        in_stamp,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [15:0]        out_heading,
  output logic [31:0]        out_var_xx,
  output logic signed [31:0] out_cov_xy,
  output logic [31:0]        out_var_yy,
  output logic [31:0]        out_var_heading,
  output logic [47:0]        out_stamp
);

  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic [15:0]        base_heading;
    logic [31:0]        var_xx;
    logic signed [31:0] cov_xy;
    logic [31:0]        var_yy;
    logic [31:0]        var_heading;
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic [15:0]        rel_heading;
    logic [47:0]        stamp;
  } item_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648) r = 32'sh8000_0000;
    else r = 32'(v);
    return r;
  endfunction

  // Join a split 31x64 product and drop 30 fraction bits
  function automatic logic [63:0] join_shr30(input logic [62:0] hi, input logic [62:0] lo);
    logic [95:0] f;
    f = {1'b0, hi, 32'b0} + 96'(lo);
    return f[93:30];
  endfunction

  // Join a split 64x32 product, scale by the position fraction, saturate
  function automatic logic [63:0] join_cov(input logic [63:0] hi, input logic [63:0] lo);
    logic [95:0] f;
    logic [95:0] sh;
    f  = {hi, 32'b0} + 96'(lo);
    sh = f >> COV_SHIFT;
    return ((f >> (64 + COV_SHIFT)) != '0) ? '1 : sh[63:0];
  endfunction

  function automatic logic [31:0] add_sat_u32(input logic [31:0] b, input logic [63:0] a);
    logic [32:0] s;
    s = 33'(b) + 33'(a[31:0]);
    return ((a[63:32] != '0) || s[32]) ? '1 : s[31:0];
  endfunction

  item_t              in_item;
  logic               in_vld;
  logic [15:0]        in_hd_sum;
  logic [ANGLE_BITS+15:0] ang_ext;
  sc_res_t            sc;
  item_t              dly_r [1:SC_LAT];
  item_t              bk_r  [1:BK_LAT-1];
  logic [BK_LAT:1]    bv_r;
  logic [31:0]        ax, ay;
  logic [30:0]        as_m, ac_m;
  // stage 1
  logic signed [63:0] cx_r, sy_r, sx_r, cy_r;
  logic [61:0]        s2p_r, c2p_r, scp_r;
  logic [63:0]        rx2_r, ry2_r;
  logic               sneg_r, cneg_r;
  // stage 2
  logic signed [64:0] dx_r, dy_r;
  logic [30:0]        s2_r, c2_r, scm_r;
  logic [63:0]        rx2b_r, ry2b_r, dmag_r;
  logic               neg_r [2:BK_LAT-1];
  // stage 3
  logic signed [31:0] px_r [3:BK_LAT-1];
  logic signed [31:0] py_r [3:BK_LAT-1];
  logic [62:0]        pxs_l_r, pxs_h_r, pyc_l_r, pyc_h_r;
  logic [62:0]        pxc_l_r, pxc_h_r, pys_l_r, pys_h_r, psc_l_r, psc_h_r;
  // stage 4
  logic [63:0]        txs_r, tyc_r, txc_r, tys_r, tsc_r;
  // stage 5
  logic [63:0]        txx_r, tyy_r, txy_r;
  // stage 6
  logic [63:0]        qxx_l_r, qxx_h_r, qyy_l_r, qyy_h_r, qxy_l_r, qxy_h_r;
  // stage 7
  logic [63:0]        dxx_r, dyy_r, dxy_r;
  // stage 8
  logic [33:0]        xym;
  logic signed [35:0] xyv;

  assign busy   = !rst_n;
  assign in_vld = start && !busy;
  assign in_item = '{base_x: in_base_x, base_y: in_base_y, base_heading: in_base_heading,
                     var_xx: in_var_xx, cov_xy: in_cov_xy, var_yy: in_var_yy,
                     var_heading: in_var_heading, rel_x: in_rel_x, rel_y: in_rel_y,
                     rel_heading: in_rel_heading, stamp: in_stamp};
  assign in_hd_sum = in_base_heading + in_rel_heading;

  // Rescale the 16-bit heading to the sine unit's angle width
  assign ang_ext = {in_base_heading, ANGLE_BITS'(0)};

  pcc_sincos u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_angle (ang_ext[ANGLE_BITS+15 -: ANGLE_BITS]),
    .res      (sc)
  );

  // Hold each item level with its sine and cosine
  always_ff @(posedge clk) begin
    dly_r[1] <= in_item;
    for (int j = 2; j <= SC_LAT; j++) begin
      dly_r[j] <= dly_r[j-1];
    end
  end

  // Advance the back-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else begin
      bv_r <= {bv_r[BK_LAT-1:1], sc.vld};
    end
  end

  // Carry the item through the back end
  always_ff @(posedge clk) begin
    bk_r[1] <= dly_r[SC_LAT];
    for (int j = 2; j <= BK_LAT - 1; j++) begin
      bk_r[j] <= bk_r[j-1];
    end
  end

  // Magnitudes of offsets, sine and cosine
  always_comb begin
    ax   = dly_r[SC_LAT].rel_x[31] ? 32'(~dly_r[SC_LAT].rel_x + 32'sd1)
                                   : 32'(dly_r[SC_LAT].rel_x);
    ay   = dly_r[SC_LAT].rel_y[31] ? 32'(~dly_r[SC_LAT].rel_y + 32'sd1)
                                   : 32'(dly_r[SC_LAT].rel_y);
    as_m = sc.s[31] ? 31'(-sc.s) : 31'(sc.s);
    ac_m = sc.c[31] ? 31'(-sc.c) : 31'(sc.c);
  end

  // Stage 1: rotation and square products
  always_ff @(posedge clk) begin
    cx_r   <= 64'(sc.c) * 64'(dly_r[SC_LAT].rel_x);
    sy_r   <= 64'(sc.s) * 64'(dly_r[SC_LAT].rel_y);
    sx_r   <= 64'(sc.s) * 64'(dly_r[SC_LAT].rel_x);
    cy_r   <= 64'(sc.c) * 64'(dly_r[SC_LAT].rel_y);
    s2p_r  <= 62'(as_m) * 62'(as_m);
    c2p_r  <= 62'(ac_m) * 62'(ac_m);
    scp_r  <= 62'(as_m) * 62'(ac_m);
    rx2_r  <= 64'(ax) * 64'(ax);
    ry2_r  <= 64'(ay) * 64'(ay);
    sneg_r <= sc.s[31];
    cneg_r <= sc.c[31];
  end

  // Stage 2: rotated offsets, truncated trig squares, offset difference;
  // carry the cross-term sign
  always_ff @(posedge clk) begin
    dx_r      <= 65'(cx_r) - 65'(sy_r);
    dy_r      <= 65'(sx_r) + 65'(cy_r);
    s2_r      <= s2p_r[60:30];
    c2_r      <= c2p_r[60:30];
    scm_r     <= scp_r[60:30];
    rx2b_r    <= rx2_r;
    ry2b_r    <= ry2_r;
    dmag_r    <= (rx2_r > ry2_r) ? rx2_r - ry2_r : ry2_r - rx2_r;
    neg_r[2]  <= (sneg_r ^ cneg_r) ^ (rx2_r > ry2_r);
    for (int j = 3; j <= BK_LAT - 1; j++) begin
      neg_r[j] <= neg_r[j-1];
    end
  end

  // Stage 3: add and saturate positions; split covariance products;
  // carry the positions
  always_ff @(posedge clk) begin
    px_r[3] <= sat_s32(36'(bk_r[2].base_x) + 36'(dx_r >>> 30));
    py_r[3] <= sat_s32(36'(bk_r[2].base_y) + 36'(dy_r >>> 30));
    for (int j = 4; j <= BK_LAT - 1; j++) begin
      px_r[j] <= px_r[j-1];
      py_r[j] <= py_r[j-1];
    end
    pxs_l_r <= 63'(s2_r) * 63'(rx2b_r[31:0]);
    pxs_h_r <= 63'(s2_r) * 63'(rx2b_r[63:32]);
    pyc_l_r <= 63'(c2_r) * 63'(ry2b_r[31:0]);
    pyc_h_r <= 63'(c2_r) * 63'(ry2b_r[63:32]);
    pxc_l_r <= 63'(c2_r) * 63'(rx2b_r[31:0]);
    pxc_h_r <= 63'(c2_r) * 63'(rx2b_r[63:32]);
    pys_l_r <= 63'(s2_r) * 63'(ry2b_r[31:0]);
    pys_h_r <= 63'(s2_r) * 63'(ry2b_r[63:32]);
    psc_l_r <= 63'(scm_r) * 63'(dmag_r[31:0]);
    psc_h_r <= 63'(scm_r) * 63'(dmag_r[63:32]);
  end

  // Stage 4: join partial products
  always_ff @(posedge clk) begin
    txs_r <= join_shr30(pxs_h_r, pxs_l_r);
    tyc_r <= join_shr30(pyc_h_r, pyc_l_r);
    txc_r <= join_shr30(pxc_h_r, pxc_l_r);
    tys_r <= join_shr30(pys_h_r, pys_l_r);
    tsc_r <= join_shr30(psc_h_r, psc_l_r);
  end

  // Stage 5: sum the variance terms
  always_ff @(posedge clk) begin
    txx_r <= txs_r + tyc_r;
    tyy_r <= txc_r + tys_r;
    txy_r <= tsc_r;
  end

  // Stage 6: split products with the heading variance
  always_ff @(posedge clk) begin
    qxx_l_r <= 64'(txx_r[31:0])  * 64'(bk_r[5].var_heading);
    qxx_h_r <= 64'(txx_r[63:32]) * 64'(bk_r[5].var_heading);
    qyy_l_r <= 64'(tyy_r[31:0])  * 64'(bk_r[5].var_heading);
    qyy_h_r <= 64'(tyy_r[63:32]) * 64'(bk_r[5].var_heading);
    qxy_l_r <= 64'(txy_r[31:0])  * 64'(bk_r[5].var_heading);
    qxy_h_r <= 64'(txy_r[63:32]) * 64'(bk_r[5].var_heading);
  end

  // Stage 7: join and scale the increments
  always_ff @(posedge clk) begin
    dxx_r <= join_cov(qxx_h_r, qxx_l_r);
    dyy_r <= join_cov(qyy_h_r, qyy_l_r);
    dxy_r <= join_cov(qxy_h_r, qxy_l_r);
  end

  // Stage 8: clamp the cross increment and apply it with its sign
  always_comb begin
    xym = (dxy_r > 64'h2_0000_0000) ? 34'h2_0000_0000 : dxy_r[33:0];
    xyv = neg_r[BK_LAT-1] ? 36'(bk_r[7].cov_xy) - $signed(36'(xym))
                          : 36'(bk_r[7].cov_xy) + $signed(36'(xym));
  end

  always_ff @(posedge clk) begin
    out_x           <= px_r[BK_LAT-1];
    out_y           <= py_r[BK_LAT-1];
    out_heading     <= bk_r[7].base_heading + bk_r[7].rel_heading;
    out_var_xx      <= add_sat_u32(bk_r[7].var_xx, dxx_r);
    out_var_yy      <= add_sat_u32(bk_r[7].var_yy, dyy_r);
    out_cov_xy      <= sat_s32(xyv);
    out_var_heading <= bk_r[7].var_heading;
    out_stamp       <= bk_r[7].stamp;
  end

  assign out_valid = bv_r[BK_LAT];

  `AST_IMPLY(a_out_follows_transfer, out_valid, $past(start && rst_n, LAT))
  `AST_IMPLY(a_heading_aligned, out_valid, out_heading == $past(in_hd_sum, LAT))
  `AST_IMPLY(a_stamp_aligned, out_valid, out_stamp == $past(in_stamp, LAT))
  `AST_NEVER(a_no_result_after_idle, out_valid && !$past(start, LAT))

endmodule
